FILE: rtl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and constants of the text-mode glyph rasterizer
// Geometry limits, function and register codes, and the records that pass
// from the front end to the back end.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // Geometry
  localparam int CELL_HEIGHT       = 8;
  localparam int MAX_COLUMNS       = 80;
  localparam int MAX_TEXT_ROWS     = 64;
  localparam int DEFAULT_TEXT_ROWS = 25;
  localparam int GLYPH_COUNT       = 256;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int CODE_W  = 8;
  localparam int ROW_W   = 3;
  localparam int BITS_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int NIB_W   = 4;
  localparam int PIX_W   = 32;
  localparam int SL_W    = 9;
  localparam int COL_W   = 7;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int HGT_W   = CFG_W + ROW_W;

  // Font memory: both banks share one array, bank bit on top
  localparam int FONT_DEPTH  = 2 * GLYPH_COUNT * CELL_HEIGHT;
  localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_FIXED = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_USER  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RENDER     = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TEXT_ROWS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FONT_BANK = 2'd2;

  // Render request, aligned with the font read data
  typedef struct packed {
    logic             valid;
    logic [NIB_W-1:0] fg;
    logic [NIB_W-1:0] bg;
    logic [SL_W-1:0]  sl;
    logic [COL_W-1:0] col;
    logic             le;
    logic             fe;
  } render_req_t;

  // One finished result
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [SL_W-1:0]  sl;
    logic [COL_W-1:0] col;
    logic             le;
    logic             fe;
  } result_t;

endpackage

FILE: rtl/text_mode_glyph_rasterizer_top.sv
// A render item's result passes through the registered font read and then the
// result queue before it is offered at the output.
// Throughput: one item per cycle unless input stalls; loads and renders may follow back to back.
// Input stalls only while the font read stage and the 4-entry result queue hold 4 items.
// Reset clears counters and queue and loads register defaults (80, 25, 0);
// the font memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// text_mode_glyph_rasterizer_top: 8x8 text-mode character generator
// Front end decodes and tracks raster position, back end builds pixel rows.
// ----------------------------------------------------------------------------
module text_mode_glyph_rasterizer_top import tgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [CODE_W-1:0] glyph_code_i,
  input  logic [ROW_W-1:0]  glyph_row_i,
  input  logic [BITS_W-1:0] glyph_bits_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  logic [ATTR_W-1:0] attribute_i,
  // results
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  pixel_indices_o,
  output logic [SL_W-1:0]   scanline_o,
  output logic [COL_W-1:0]  column_o,
  output logic              line_end_o,
  output logic              frame_end_o
);

  logic                   ram_we, ram_re;
  logic [FONT_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BITS_W-1:0]      ram_wdata, ram_rdata;
  logic [QCNT_W-1:0]      q_count;
  render_req_t            req;
  result_t                result;

  tgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .glyph_code_i (glyph_code_i),
    .glyph_row_i  (glyph_row_i),
    .glyph_bits_i (glyph_bits_i),
    .char_code_i  (char_code_i),
    .attribute_i  (attribute_i),
    .q_count_i    (q_count),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .req_o        (req)
  );

  // Both font banks, bank select in the top address bit
  tgr_ram #(
    .WIDTH (BITS_W),
    .DEPTH (FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rdata_i     (ram_rdata),
    .q_count_o   (q_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign pixel_indices_o = result.pix;
  assign scanline_o      = result.sl;
  assign column_o        = result.col;
  assign line_end_o      = result.le;
  assign frame_end_o     = result.fe;

`ifndef NO_ASSERTIONS
  // Queue never overruns
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(Q_DEPTH))
    else $error("result queue overrun");

  // A request in the read stage comes only from an accepted render item
  a_req_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |-> $past(in_valid_i && in_ready_o && func_i == FUNC_RENDER))
    else $error("read-stage request without render transfer");

  // Full credit blocks input
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == QCNT_W'(Q_DEPTH)) |-> !in_ready_o)
    else $error("input ready while queue full");

  // End of frame is always also end of line
  a_fe_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> line_end_o)
    else $error("frame end without line end");
`endif

endmodule

FILE: rtl/tgr_ram.sv
// ----------------------------------------------------------------------------
// tgr_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front: input decode, configuration and raster position tracking
// Loads go straight to the font memory; render items advance the column and
// scanline counters, issue a font read and hand a request to the back end.
// ----------------------------------------------------------------------------
module tgr_front import tgr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CIDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic [CODE_W-1:0]      glyph_code_i,
  input  logic [ROW_W-1:0]       glyph_row_i,
  input  logic [BITS_W-1:0]      glyph_bits_i,
  input  logic [CODE_W-1:0]      char_code_i,
  input  logic [ATTR_W-1:0]      attribute_i,
  // queue occupancy from the back end
  input  logic [QCNT_W-1:0]      q_count_i,
  // font memory
  output logic                   ram_we_o,
  output logic [FONT_ADDR_W-1:0] ram_waddr_o,
  output logic [BITS_W-1:0]      ram_wdata_o,
  output logic                   ram_re_o,
  output logic [FONT_ADDR_W-1:0] ram_raddr_o,
  // request to the back end
  output render_req_t            req_o
);

  logic [CFG_W-1:0] columns_q, text_rows_q;
  logic             font_bank_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [SL_W-1:0]  sl_q, sl_d;
  logic             req_valid_q;
  render_req_t      meta_q, meta_d;

  logic [CFG_W-1:0] cols_eff, rows_eff;
  logic [HGT_W-1:0] height;
  logic [COL_W-1:0] col_cur;
  logic [SL_W-1:0]  sl_cur;
  logic             le, fe;
  logic             accept, render_go, load_go;
  logic [QCNT_W:0]  in_flight;

  // Configuration registers, to be written only while idle; the block itself does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q   <= CFG_W'(MAX_COLUMNS);
      text_rows_q <= CFG_W'(DEFAULT_TEXT_ROWS);
      font_bank_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLUMNS:   columns_q   <= cfg_data_i;
        CFG_TEXT_ROWS: text_rows_q <= cfg_data_i;
        CFG_FONT_BANK: font_bank_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero or oversize columns and oversize rows fall back to limits, zero rows to the default
  always_comb begin
    if (columns_q == '0 || {1'b0, columns_q} > (CFG_W+1)'(MAX_COLUMNS)) begin
      cols_eff = CFG_W'(MAX_COLUMNS);
    end else begin
      cols_eff = columns_q;
    end
    if (text_rows_q == '0) begin
      rows_eff = CFG_W'(DEFAULT_TEXT_ROWS);
    end else if ({1'b0, text_rows_q} > (CFG_W+1)'(MAX_TEXT_ROWS)) begin
      rows_eff = CFG_W'(MAX_TEXT_ROWS);
    end else begin
      rows_eff = text_rows_q;
    end
    height = {rows_eff, {ROW_W{1'b0}}};
  end

  // Credit check: queue entries plus the request in the read stage
  assign in_flight  = {1'b0, q_count_i} + (QCNT_W+1)'(req_valid_q);
  assign in_ready_o = in_flight < (QCNT_W+1)'(Q_DEPTH);

  assign accept    = in_valid_i && in_ready_o;
  assign render_go = accept && (func_i == FUNC_RENDER);
  assign load_go   = accept && (func_i == FUNC_LOAD_FIXED || func_i == FUNC_LOAD_USER);

  // Position of this cell; stale counters beyond the geometry wrap to zero
  always_comb begin
    col_cur = ({1'b0, col_q} >= {1'b0, cols_eff}) ? '0 : col_q;
    sl_cur  = ({1'b0, sl_q} >= height) ? '0 : sl_q;
    le      = ({1'b0, col_cur} == ({1'b0, cols_eff} - 8'd1));
    fe      = le && ({1'b0, sl_cur} == (height - HGT_W'(1)));
    if (le) begin
      col_d = '0;
      sl_d  = fe ? '0 : sl_cur + SL_W'(1);
    end else begin
      col_d = col_cur + COL_W'(1);
      sl_d  = sl_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sl_q  <= '0;
    end else if (render_go) begin
      col_q <= col_d;
      sl_q  <= sl_d;
    end
  end

  // Font memory access
  assign ram_we_o    = load_go;
  assign ram_waddr_o = {func_i[0], glyph_code_i, glyph_row_i};
  assign ram_wdata_o = glyph_bits_i;
  assign ram_re_o    = render_go;
  assign ram_raddr_o = {font_bank_q, char_code_i, sl_cur[ROW_W-1:0]};

  // Read stage: request metadata is registered along with the font read, so both arrive together
  always_comb begin
    meta_d       = '0;
    meta_d.valid = 1'b1;
    meta_d.fg    = attribute_i[NIB_W-1:0];
    meta_d.bg    = attribute_i[ATTR_W-1:NIB_W];
    meta_d.sl    = sl_cur;
    meta_d.col   = col_cur;
    meta_d.le    = le;
    meta_d.fe    = fe;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= render_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_go) begin
      meta_q <= meta_d;
    end
  end

  always_comb begin
    req_o       = meta_q;
    req_o.valid = req_valid_q;
  end

endmodule

FILE: rtl/tgr_back.sv
// ----------------------------------------------------------------------------
// tgr_back: pixel expansion and result queue
// Turns a glyph row and attribute into eight colour indices and buffers the
// results until the output side takes them.
// ----------------------------------------------------------------------------
module tgr_back import tgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  render_req_t       req_i,
  input  logic [BITS_W-1:0] rdata_i,
  output logic [QCNT_W-1:0] q_count_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           result_o
);

  result_t           q_mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  result_t           res_d;
  logic              push, pop;

  // Set bit picks foreground, clear bit background; bit 7 goes on top
  always_comb begin
    res_d = '0;
    for (int i = 0; i < BITS_W; i++) begin
      res_d.pix[i*NIB_W +: NIB_W] = rdata_i[i] ? req_i.fg : req_i.bg;
    end
    res_d.sl  = req_i.sl;
    res_d.col = req_i.col;
    res_d.le  = req_i.le;
    res_d.fe  = req_i.fe;
  end

  assign push = req_i.valid;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= res_d;
    end
  end

  assign q_count_o   = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign result_o    = q_mem_q[rd_ptr_q];

endmodule
